>>> rtl/core/c3b_pkg.sv
// ----------------------------------------------------------------------------
// c3b_pkg
// shared types and constants of the 3x3 rgb convolution with border modes
// ----------------------------------------------------------------------------
package c3b_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int ROW_W     = FH_W + 1;
  localparam int COEF_W    = 48;

  typedef logic [23:0] pix_t;

  typedef enum logic [1:0] {
    EDGE_CONST   = 2'd0,
    EDGE_CLAMP   = 2'd1,
    EDGE_REFLECT = 2'd2,
    EDGE_MIRROR  = 2'd3
  } edge_mode_t;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_EDGE_MODE    = 3'd2;
  localparam logic [2:0] REG_PAD_VALUE    = 3'd3;
  localparam logic [2:0] REG_COEF_TOP     = 3'd4;
  localparam logic [2:0] REG_COEF_MID     = 3'd5;
  localparam logic [2:0] REG_COEF_BOTTOM  = 3'd6;

  // effective geometry and kernel as the datapath sees it
  typedef struct packed {
    logic [FW_W-1:0]   width;
    logic [FH_W-1:0]   height;
    edge_mode_t        mode;
    logic [7:0]        value;
    logic [COEF_W-1:0] coef_top;
    logic [COEF_W-1:0] coef_mid;
    logic [COEF_W-1:0] coef_bot;
  } cfg_t;

  // one output pixel job: resolved 3x3 taps, tap index row*3+col
  typedef struct packed {
    pix_t [8:0] taps;
    logic       eol;
    logic       eof;
  } job_t;

endpackage

>>> rtl/core/c3b_regs.sv
// ----------------------------------------------------------------------------
// c3b_regs
// apb register file, gives effective frame geometry and kernel
// ----------------------------------------------------------------------------
module c3b_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output c3b_pkg::cfg_t       cfg
);

  logic [c3b_pkg::FW_W-1:0]   frame_width;
  logic [c3b_pkg::FH_W-1:0]   frame_height;
  logic [1:0]                 edge_mode;
  logic [7:0]                 pad_value;
  logic [c3b_pkg::COEF_W-1:0] coef_top;
  logic [c3b_pkg::COEF_W-1:0] coef_mid;
  logic [c3b_pkg::COEF_W-1:0] coef_bot;
  logic [2:0]                 idx;
  logic                       wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd1024;
      frame_height <= 12'd480;
      edge_mode    <= 2'd0;
      pad_value    <= 8'd0;
      coef_top     <= '0;
      coef_mid     <= 48'd16777216;
      coef_bot     <= '0;
    end else if (wr) begin
      unique case (idx)
        c3b_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[c3b_pkg::FW_W-1:0];
        c3b_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[c3b_pkg::FH_W-1:0];
        c3b_pkg::REG_EDGE_MODE:    edge_mode    <= pwdata[1:0];
        c3b_pkg::REG_PAD_VALUE:    pad_value    <= pwdata[7:0];
        c3b_pkg::REG_COEF_TOP:     coef_top     <= pwdata[c3b_pkg::COEF_W-1:0];
        c3b_pkg::REG_COEF_MID:     coef_mid     <= pwdata[c3b_pkg::COEF_W-1:0];
        c3b_pkg::REG_COEF_BOTTOM:  coef_bot     <= pwdata[c3b_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      c3b_pkg::REG_FRAME_WIDTH:  prdata = 64'(frame_width);
      c3b_pkg::REG_FRAME_HEIGHT: prdata = 64'(frame_height);
      c3b_pkg::REG_EDGE_MODE:    prdata = 64'(edge_mode);
      c3b_pkg::REG_PAD_VALUE:    prdata = 64'(pad_value);
      c3b_pkg::REG_COEF_TOP:     prdata = 64'(coef_top);
      c3b_pkg::REG_COEF_MID:     prdata = 64'(coef_mid);
      c3b_pkg::REG_COEF_BOTTOM:  prdata = 64'(coef_bot);
      default:                   prdata = '0;
    endcase
  end

  // zero width acts as one, above the line store depth clamps to it
  always_comb begin
    if (frame_width == '0) begin
      cfg.width = c3b_pkg::FW_W'(1);
    end else if (frame_width > c3b_pkg::FW_W'(c3b_pkg::MAX_WIDTH)) begin
      cfg.width = c3b_pkg::FW_W'(c3b_pkg::MAX_WIDTH);
    end else begin
      cfg.width = frame_width;
    end
    cfg.height   = (frame_height == '0) ? c3b_pkg::FH_W'(1) : frame_height;
    cfg.mode     = c3b_pkg::edge_mode_t'(edge_mode);
    cfg.value    = pad_value;
    cfg.coef_top = coef_top;
    cfg.coef_mid = coef_mid;
    cfg.coef_bot = coef_bot;
  end

endmodule

>>> rtl/core/c3b_front.sv
// ----------------------------------------------------------------------------
// c3b_front
// input counters, line stores, window and border tap selection
// ----------------------------------------------------------------------------
module c3b_front (
  input  logic          clk,
  input  logic          rst,
  input  c3b_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_ch0,
  input  logic [7:0]    in_ch1,
  input  logic [7:0]    in_ch2,
  input  logic          is_padding,
  output logic          job_valid,
  input  logic          job_ready,
  output c3b_pkg::job_t job
);

  localparam int CW = c3b_pkg::COL_W;
  localparam int RW = c3b_pkg::ROW_W;

  typedef struct packed {
    logic                 valid;
    c3b_pkg::pix_t        pixel;
    logic [CW-1:0]        j;
    logic                 shift;
    logic                 emit;
    logic                 late;
    logic                 frame_end;
  } stage_t;

  function automatic logic signed [15:0] ext(input logic [RW-1:0] v);
    return signed'({{(16-RW){1'b0}}, v});
  endfunction

  function automatic logic is_out(input logic [RW-1:0] p, input logic signed [1:0] d,
                                  input logic [RW-1:0] n);
    logic signed [15:0] t;
    t = ext(p) + {{14{d[1]}}, d};
    return (t < 16'sd0) || (t >= ext(n));
  endfunction

  // offset -1..1 from p to the coordinate that stands for p + d
  function automatic logic signed [1:0] border_off(input logic [RW-1:0] p,
                                                   input logic signed [1:0] d,
                                                   input logic [RW-1:0] n,
                                                   input c3b_pkg::edge_mode_t mode);
    logic signed [15:0] ps;
    logic signed [15:0] ns;
    logic signed [15:0] t;
    logic signed [15:0] o;
    ps = ext(p);
    ns = ext(n);
    t  = ps + {{14{d[1]}}, d};
    if ((t < 16'sd0) || (t >= ns)) begin
      if (mode == c3b_pkg::EDGE_REFLECT) begin
        t = (t < 16'sd0) ? (-t - 16'sd1) : (16'sd2 * ns - 16'sd1 - t);
      end else if ((mode == c3b_pkg::EDGE_MIRROR) && (ns >= 16'sd2)) begin
        t = (t < 16'sd0) ? (-t) : (16'sd2 * ns - 16'sd2 - t);
      end
      if (t < 16'sd0) begin
        t = 16'sd0;
      end else if (t > ns - 16'sd1) begin
        t = ns - 16'sd1;
      end
    end
    o = t - ps;
    if (o < -16'sd1) begin
      o = -16'sd1;
    end else if (o > 16'sd1) begin
      o = 16'sd1;
    end
    return o[1:0];
  endfunction

  logic [CW-1:0]  in_column;
  logic [RW-1:0]  in_row;
  logic [CW-1:0]  out_column;
  logic [RW-1:0]  out_row;
  stage_t         f1;
  c3b_pkg::pix_t  rd_upper;
  c3b_pkg::pix_t  rd_lower;
  c3b_pkg::pix_t  mem_upper [c3b_pkg::MAX_WIDTH];
  c3b_pkg::pix_t  mem_lower [c3b_pkg::MAX_WIDTH];
  c3b_pkg::pix_t  win    [3][3];
  c3b_pkg::pix_t  win_next [3][3];
  c3b_pkg::pix_t  ew     [3][3];

  logic           accept;
  logic           go;
  logic           wr_en;
  logic           wrap;
  logic [CW-1:0]  col_w;
  logic [RW-1:0]  row_w;
  logic [RW-1:0]  hx;
  logic [RW-1:0]  wx;
  logic           in_frame;
  logic           drop;
  logic           e1;
  logic           e2;
  logic           fr;
  logic [CW:0]    c1;
  logic           adv_wrap;
  logic [1:0]     cslot;
  logic           eol;
  logic           eof;
  logic signed [1:0] roff [3];
  logic signed [1:0] coff [3];
  logic           rout [3];
  logic           cout [3];

  assign hx = RW'(cfg.height);
  assign wx = RW'(cfg.width);

  assign go       = f1.valid && (!f1.emit || job_ready);
  assign in_ready = !f1.valid || go;
  assign accept   = in_valid && in_ready;
  assign wr_en    = go && f1.shift;

  // classification of the incoming beat against the counters
  always_comb begin
    wrap     = ({1'b0, in_column} >= cfg.width);
    col_w    = wrap ? '0 : in_column;
    row_w    = wrap ? in_row + RW'(1) : in_row;
    in_frame = row_w < hx;
    drop     = in_frame && is_padding;
    fr       = row_w > hx;
    e2       = (col_w == '0) && (row_w >= RW'(2));
    e1       = !fr && (col_w != '0) && (row_w >= RW'(1));
    c1       = {1'b0, col_w} + (CW+1)'(1);
    adv_wrap = c1 >= cfg.width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (accept) begin
      if (drop) begin
        in_column <= col_w;
        in_row    <= row_w;
      end else if (fr) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (adv_wrap) begin
        in_column <= '0;
        in_row    <= row_w + RW'(1);
      end else begin
        in_column <= c1[CW-1:0];
        in_row    <= row_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1.valid <= 1'b0;
    end else if (accept) begin
      f1.valid <= !drop;
    end else if (go) begin
      f1.valid <= 1'b0;
    end
    if (accept) begin
      f1.pixel     <= in_frame ? {in_ch2, in_ch1, in_ch0} : '0;
      f1.j         <= col_w;
      f1.shift     <= !fr;
      f1.emit      <= e1 || e2;
      f1.late      <= e1;
      f1.frame_end <= fr;
    end
  end

  // line stores, read at accept with the write of the stage ahead forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[f1.j] <= rd_lower;
      mem_lower[f1.j] <= f1.pixel;
    end
    if (accept) begin
      rd_upper <= (wr_en && (f1.j == col_w)) ? rd_lower : mem_upper[col_w];
      rd_lower <= (wr_en && (f1.j == col_w)) ? f1.pixel : mem_lower[col_w];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = rd_upper;
    win_next[1][2] = rd_lower;
    win_next[2][2] = f1.pixel;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ew[r][c] = f1.late ? win_next[r][c] : win[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (wr_en) begin
      win <= win_next;
    end
  end

  // border handling per kernel row and column
  always_comb begin
    logic signed [1:0] d;
    logic [2:0]        cs;
    cslot = f1.late ? 2'd1 : 2'd2;
    for (int i = 0; i < 3; i++) begin
      d       = 2'(1 - i);
      roff[i] = border_off(out_row, d, hx, cfg.mode);
      rout[i] = is_out(out_row, d, hx);
      coff[i] = border_off(RW'(out_column), d, wx, cfg.mode);
      cout[i] = is_out(RW'(out_column), d, wx);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        cs = 3'({1'b0, cslot}) + {{1{coff[k][1]}}, coff[k]};
        if (cs[2]) begin
          cs = 3'd0;
        end else if (cs > 3'd2) begin
          cs = 3'd2;
        end
        if ((rout[i] || cout[k]) && (cfg.mode == c3b_pkg::EDGE_CONST)) begin
          job.taps[i*3+k] = {cfg.value, cfg.value, cfg.value};
        end else begin
          job.taps[i*3+k] = ew[2'(roff[i] + 2'sd1)][cs[1:0]];
        end
      end
    end
    eol     = ({1'b0, out_column} + (CW+1)'(1)) >= cfg.width;
    eof     = eol && ((out_row + RW'(1)) >= hx);
    job.eol = eol;
    job.eof = eof;
  end

  assign job_valid = f1.valid && f1.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_column <= '0;
      out_row    <= '0;
    end else if (go) begin
      if (f1.frame_end) begin
        out_column <= '0;
        out_row    <= '0;
      end else if (f1.emit) begin
        if (eol) begin
          out_column <= '0;
          out_row    <= out_row + RW'(1);
        end else begin
          out_column <= out_column + CW'(1);
        end
      end
    end
  end

endmodule

>>> rtl/core/c3b_queue.sv
// ----------------------------------------------------------------------------
// c3b_queue
// two-entry job queue between tap selection and the mac pipeline
// ----------------------------------------------------------------------------
module c3b_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  c3b_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output c3b_pkg::job_t pop_data
);

  c3b_pkg::job_t slot [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/c3b_back.sv
// ----------------------------------------------------------------------------
// c3b_back
// multiply, sum, round and saturate pipeline with the output register
// ----------------------------------------------------------------------------
module c3b_back (
  input  logic          clk,
  input  logic          rst,
  input  c3b_pkg::cfg_t cfg,
  input  logic          job_valid,
  output logic          job_ready,
  input  c3b_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_ch0,
  output logic [7:0]    out_ch1,
  output logic [7:0]    out_ch2,
  output logic          end_of_line,
  output logic          end_of_frame
);

  logic                adv;
  logic                s1_valid;
  logic                s2_valid;
  logic signed [24:0]  prod [9][3];
  logic signed [26:0]  grp  [3][3];
  logic                s1_eol;
  logic                s1_eof;
  logic                s2_eol;
  logic                s2_eof;
  logic [47:0]         row_coef [3];
  logic [7:0]          res  [3];

  assign adv       = !out_valid || out_ready;
  assign job_ready = adv;

  assign row_coef[0] = cfg.coef_top;
  assign row_coef[1] = cfg.coef_mid;
  assign row_coef[2] = cfg.coef_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= job_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // signed q8.8 coefficient times unsigned channel
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          for (int ch = 0; ch < 3; ch++) begin
            prod[i*3+k][ch] <= $signed(row_coef[i][16*k +: 16]) *
                               $signed({1'b0, job.taps[i*3+k][8*ch +: 8]});
          end
        end
      end
      s1_eol <= job.eol;
      s1_eof <= job.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int ch = 0; ch < 3; ch++) begin
          grp[i][ch] <= 27'(prod[i*3][ch]) + 27'(prod[i*3+1][ch]) +
                        27'(prod[i*3+2][ch]);
        end
      end
      s2_eol <= s1_eol;
      s2_eof <= s1_eof;
    end
  end

  // round half up, clamp to 0..255
  always_comb begin
    logic signed [28:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      v = 29'(grp[0][ch]) + 29'(grp[1][ch]) + 29'(grp[2][ch]) + 29'sd128;
      if (v <= 29'sd0) begin
        res[ch] = 8'd0;
      end else if (v[28:8] > 21'd255) begin
        res[ch] = 8'd255;
      end else begin
        res[ch] = v[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch0      <= res[0];
      out_ch1      <= res[1];
      out_ch2      <= res[2];
      end_of_line  <= s2_eol;
      end_of_frame <= s2_eof;
    end
  end

endmodule

>>> rtl/core/conv3x3_rgb_border_modes.sv
// ----------------------------------------------------------------------------
// conv3x3_rgb_border_modes
// streaming 3x3 convolution of rgb pixels with selectable border handling
// ----------------------------------------------------------------------------
// usage
//   input channel: raster pixels (in_ch0..2) with in_valid / in_ready; after
//   the last pixel of a frame send frame_width + 1 items with is_padding set
//   to flush the last line. padding inside a frame is dropped
//   output channel: filtered pixels with end_of_line / end_of_frame flags,
//   out_valid / out_ready
//   apb port: 64-bit registers at 8 * index, write only while idle
// throughput: one item per cycle while out_ready stays high; the window, line stores and tap select
//   take one item each cycle, the mac pipeline one job each cycle
// path: after the item that completes its window, a result passes the read stage,
//   queue, multiply, sum and output register; each output pixel inherently trails
//   its input by frame_width + 1 items
// reset: counters, window and queue cleared; line stores hold no reset and
//   are written before their data is used
// stall: out_ready low freezes the mac pipeline, the queue fills, then
//   in_ready drops; nothing is lost
// ----------------------------------------------------------------------------
module conv3x3_rgb_border_modes (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  input  logic        is_padding,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic        end_of_line,
  output logic        end_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  c3b_pkg::cfg_t cfg;
  c3b_pkg::job_t fjob;
  c3b_pkg::job_t bjob;
  logic          fjob_valid;
  logic          fjob_ready;
  logic          bjob_valid;
  logic          bjob_ready;

  // register file
  c3b_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // counters, line stores, window, border taps
  c3b_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch0     (in_ch0),
    .in_ch1     (in_ch1),
    .in_ch2     (in_ch2),
    .is_padding (is_padding),
    .job_valid  (fjob_valid),
    .job_ready  (fjob_ready),
    .job        (fjob)
  );

  // decouples tap selection from the mac pipeline
  c3b_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fjob_valid),
    .push_ready (fjob_ready),
    .push_data  (fjob),
    .pop_valid  (bjob_valid),
    .pop_ready  (bjob_ready),
    .pop_data   (bjob)
  );

  // multiply, accumulate, round, saturate
  c3b_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (bjob_valid),
    .job_ready    (bjob_ready),
    .job          (bjob),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
  );

endmodule
